// ----- sv/dvr_pkg.sv -----
`timescale 1ns / 1ps
package dvr_pkg;

  localparam int DEFAULT_NODES = 8;
  localparam int DEFAULT_COST_BITS = 16;
  // nodes that have a link cost field in the configuration
  localparam int LINK_NODES = 8;
  localparam logic [15:0] RESET_INFINITE = 16'd999;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_INIT   = 2'd2
  } dvr_op_t;

  typedef enum logic [2:0] {
    CFG_MY_NODE   = 3'd0,
    CFG_NBR_MASK  = 3'd1,
    CFG_COST_LOW  = 3'd2,
    CFG_COST_HIGH = 3'd3,
    CFG_INF_COST  = 3'd4
  } dvr_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_RELAX
  } dvr_state_t;

  typedef struct packed {
    logic [2:0]  my_node_id;
    logic [7:0]  neighbor_mask;
    logic [63:0] nbr_cost_low;
    logic [63:0] nbr_cost_high;
    logic [15:0] infinite_cost;
  } dvr_cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  src_node;
    logic [2:0]  entry_node;
    logic [15:0] entry_cost;
    logic [2:0]  dest_node;
    logic        last;
  } dvr_item_t;

  typedef struct packed {
    logic       deliver_local;
    logic       found;
    logic [2:0] next_hop;
    logic       routes_changed;
  } dvr_result_t;

  typedef struct packed {
    logic wr_en;
    logic clear;
  } dvr_mem_ctl_t;

endpackage

// ----- sv/dvr_store.sv -----
`timescale 1ns / 1ps
module dvr_store #(
  parameter int NODES = dvr_pkg::DEFAULT_NODES,
  parameter int COST_BITS = dvr_pkg::DEFAULT_COST_BITS,
  localparam int AW = $clog2(NODES * NODES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dvr_pkg::dvr_mem_ctl_t ctl,
  input  logic [AW-1:0]         waddr,
  input  logic [COST_BITS-1:0]  wdata,
  input  logic [AW-1:0]         raddr,
  output logic [COST_BITS-1:0]  rdata
);
  import dvr_pkg::*;

  localparam int DEPTH = NODES * NODES;
  localparam logic [COST_BITS-1:0] RESET_INF =
    (COST_BITS >= 10) ? COST_BITS'(RESET_INFINITE) : {COST_BITS{1'b1}};

  logic [COST_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid;
  logic [COST_BITS-1:0] fill;
  logic [COST_BITS-1:0] mem_q;
  logic                 valid_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // entries not written since the last clear read as the fill value
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      fill    <= RESET_INF;
      valid_q <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid <= '0;
        fill  <= wdata;
      end else if (ctl.wr_en) begin
        valid[waddr] <= 1'b1;
      end
      valid_q <= valid[raddr];
    end
  end

  assign rdata = valid_q ? mem_q : fill;

endmodule

// ----- sv/dvr_seq.sv -----
`timescale 1ns / 1ps
module dvr_seq #(
  parameter int NODES = dvr_pkg::DEFAULT_NODES,
  parameter int COST_BITS = dvr_pkg::DEFAULT_COST_BITS,
  localparam int AW = $clog2(NODES * NODES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dvr_pkg::dvr_cfg_t     cfg,
  input  logic                  accept,
  input  dvr_pkg::dvr_item_t    item,
  output logic                  idle,
  output logic                  res_push,
  output dvr_pkg::dvr_result_t  res,
  output dvr_pkg::dvr_mem_ctl_t mem_ctl,
  output logic [AW-1:0]         waddr,
  output logic [COST_BITS-1:0]  wdata,
  output logic [AW-1:0]         raddr,
  input  logic [COST_BITS-1:0]  rdata
);
  import dvr_pkg::*;

  localparam int NB = $clog2(NODES);
  localparam int KB = NB + 1;
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  function automatic logic [COST_BITS-1:0] clamp_cost(logic [15:0] c,
                                                      logic [COST_BITS-1:0] lim);
    return (33'(c) < 33'(lim)) ? COST_BITS'(c) : lim;
  endfunction

  function automatic logic nbr_of(logic [4:0] n, logic [2:0] me, logic [7:0] mask);
    return (n < 5'(LINK_NODES)) && (32'(n) < NODES) && (n != 5'(me)) && mask[n[2:0]];
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [4:0] row, logic [4:0] col);
    return AW'(AW'(row) * AW'(NODES) + AW'(col));
  endfunction

  dvr_state_t state, state_next;

  logic [KB-1:0]        k;
  logic [NB-1:0]        d;
  logic                 issuing;
  logic                 p_valid;
  logic [KB-1:0]        p_k;
  logic [NB-1:0]        p_d;
  logic                 p_nbr;
  logic [COST_BITS-1:0] p_link;
  logic [COST_BITS-1:0] best;
  logic                 changed;
  logic [NB-1:0]        c;
  logic [2:0]           hop_table [NODES];
  logic [NODES-1:0]     hop_valid;

  logic [LINK_NODES-1:0][15:0] link_raw;
  logic [COST_BITS-1:0] inf_cost;
  logic [COST_BITS-1:0] link_k;
  logic [COST_BITS-1:0] link_c;
  logic [4:0]           me5;
  logic [4:0]           kn5;
  logic [4:0]           pn5;
  logic [4:0]           c5;
  logic                 me_ok;
  logic                 store_ok;
  logic [COST_BITS:0]   sum;
  logic [COST_BITS-1:0] sat;
  logic                 improve;
  logic                 done_relax;
  logic                 start_relax;
  logic                 start_init;

  assign link_raw = {cfg.nbr_cost_high, cfg.nbr_cost_low};
  assign inf_cost = (33'(cfg.infinite_cost) < 33'(COST_MAX)) ?
                    COST_BITS'(cfg.infinite_cost) : COST_MAX;
  assign me5   = 5'(cfg.my_node_id);
  assign me_ok = 32'(cfg.my_node_id) < NODES;
  assign kn5   = 5'(k) - 5'd1;
  assign pn5   = 5'(p_k) - 5'd1;
  assign c5    = 5'(c);

  assign link_k = (kn5 < 5'(LINK_NODES)) ? clamp_cost(link_raw[kn5[2:0]], inf_cost)
                                         : inf_cost;
  assign link_c = (c5 < 5'(LINK_NODES)) ? clamp_cost(link_raw[c5[2:0]], inf_cost)
                                        : inf_cost;

  assign store_ok = (32'(item.src_node) < NODES) && (32'(item.entry_node) < NODES) &&
                    (item.src_node != cfg.my_node_id);

  // relaxation: link cost plus neighbor's advertised cost, saturated
  assign sum = {1'b0, p_link} + {1'b0, rdata};
  assign sat = (sum > {1'b0, inf_cost}) ? inf_cost : sum[COST_BITS-1:0];
  assign improve = (state == ST_RELAX) && p_valid && (p_k != '0) && p_nbr && (sat < best);
  assign done_relax = (state == ST_RELAX) && p_valid && (p_k == KB'(NODES)) &&
                      (p_d == NB'(NODES - 1));

  assign start_relax = (state == ST_IDLE) && accept && (item.opcode == OP_UPDATE) &&
                       item.last && me_ok;
  assign start_init  = (state == ST_IDLE) && accept && (item.opcode == OP_INIT);

  // slot zero of each destination reads the own row, the rest read neighbor rows
  assign raddr = (k == '0) ? addr_of(me5, 5'(d)) : addr_of(kn5, 5'(d));
  assign idle  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_ctl    = '0;
    waddr      = '0;
    wdata      = '0;
    res        = '0;
    res_push   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (item.opcode)
            OP_UPDATE: begin
              if (store_ok) begin
                mem_ctl.wr_en = 1'b1;
                waddr = addr_of(5'(item.src_node), 5'(item.entry_node));
                wdata = clamp_cost(item.entry_cost, inf_cost);
              end
              if (item.last && me_ok) begin
                state_next = ST_RELAX;
              end else begin
                res_push = 1'b1;
              end
            end
            OP_LOOKUP: begin
              res_push = 1'b1;
              if (item.dest_node == cfg.my_node_id) begin
                res.deliver_local = 1'b1;
              end else if ((32'(item.dest_node) < NODES) &&
                           hop_valid[NB'(item.dest_node)]) begin
                res.found    = 1'b1;
                res.next_hop = hop_table[NB'(item.dest_node)];
              end
            end
            OP_INIT: begin
              mem_ctl.clear = 1'b1;
              wdata = inf_cost;
              res_push = 1'b1;
              if (me_ok) begin
                state_next = ST_INIT;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_INIT: begin
        mem_ctl.wr_en = 1'b1;
        waddr = addr_of(me5, c5);
        if (c5 == me5) begin
          wdata = '0;
        end else if (nbr_of(c5, cfg.my_node_id, cfg.neighbor_mask)) begin
          wdata = link_c;
        end else begin
          wdata = inf_cost;
        end
        if (c == NB'(NODES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_RELAX: begin
        if (improve) begin
          mem_ctl.wr_en = 1'b1;
          waddr = addr_of(me5, 5'(p_d));
          wdata = sat;
        end
        if (done_relax) begin
          res_push = 1'b1;
          res.routes_changed = changed | improve;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      d         <= '0;
      c         <= '0;
      issuing   <= 1'b0;
      p_valid   <= 1'b0;
      changed   <= 1'b0;
      hop_valid <= '0;
      hop_table <= '{default: '0};
    end else begin
      if (start_init) begin
        hop_valid <= '0;
        hop_table <= '{default: '0};
        c <= '0;
      end
      if (start_relax) begin
        issuing <= 1'b1;
        k <= '0;
        d <= '0;
        changed <= 1'b0;
      end
      if (state == ST_INIT) begin
        if (nbr_of(c5, cfg.my_node_id, cfg.neighbor_mask)) begin
          hop_table[c] <= c5[2:0];
          hop_valid[c] <= 1'b1;
        end
        c <= c + NB'(1);
      end
      if (state == ST_RELAX) begin
        p_valid <= issuing;
        if (issuing) begin
          p_k    <= k;
          p_d    <= d;
          p_nbr  <= nbr_of(kn5, cfg.my_node_id, cfg.neighbor_mask);
          p_link <= link_k;
          if (k == KB'(NODES)) begin
            k <= '0;
            if (d == NB'(NODES - 1)) begin
              issuing <= 1'b0;
            end else begin
              d <= d + NB'(1);
            end
          end else begin
            k <= k + KB'(1);
          end
        end
        if (p_valid && (p_k == '0)) begin
          best <= rdata;
        end
        if (improve) begin
          best <= sat;
          hop_table[p_d] <= pn5[2:0];
          hop_valid[p_d] <= 1'b1;
          changed <= 1'b1;
        end
      end
    end
  end

  a_relax_start: assert property (@(posedge clk) disable iff (rst)
    start_relax |=> (state == ST_RELAX) && issuing && !p_valid)
    else $error("relaxation did not start after a final update entry");

  a_pipe_in_relax: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == ST_RELAX))
    else $error("relaxation pipeline busy outside relaxation");

  a_best_monotone: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RELAX) && p_valid && (p_k > KB'(1))) |-> (best <= $past(best)))
    else $error("best cost rose within one destination");

endmodule

// ----- sv/distance_vector_router_core.sv -----
`timescale 1ns / 1ps
// Distance-vector router. Path costs live in a NODES*NODES single-port-read
// store; next hops sit in flip-flops. A lookup, a route update entry without
// tlast and an unused opcode push their result from the idle state. An init
// clears the store: the other rows fall back to the infinite cost through
// per-entry valid flags and a fill value, and only this node's row is swept.
// A route update entry with tlast set starts the Bellman-Ford pass, which
// issues one store read per destination for its own row and for each node's
// row, one after another on the single read port. Results go to a two-entry
// output queue, so a new transaction is taken while one result still waits.
module distance_vector_router_core #(
  parameter int NODES = dvr_pkg::DEFAULT_NODES,
  parameter int COST_BITS = dvr_pkg::DEFAULT_COST_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // src_node[2:0], entry_node[5:3], entry_cost[21:6], dest_node[24:22], zero
  input  logic [31:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // deliver_local[0], found[1], next_hop[4:2], routes_changed[5], zero
  output logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import dvr_pkg::*;

  localparam int AW = $clog2(NODES * NODES);

  dvr_cfg_t             cfg;
  dvr_item_t            item;
  dvr_result_t          res;
  dvr_mem_ctl_t         mem_ctl;
  logic                 seq_idle;
  logic                 res_push;
  logic                 s_accept;
  logic                 m_pop;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [COST_BITS-1:0] wdata;
  logic [COST_BITS-1:0] rdata;

  dvr_result_t          queue [2];
  logic [1:0]           count;
  logic                 wr_ptr;
  logic                 rd_ptr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_node_id    <= '0;
      cfg.neighbor_mask <= '0;
      cfg.nbr_cost_low  <= '0;
      cfg.nbr_cost_high <= '0;
      cfg.infinite_cost <= RESET_INFINITE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MY_NODE:   cfg.my_node_id    <= cfg_data[2:0];
        CFG_NBR_MASK:  cfg.neighbor_mask <= cfg_data[7:0];
        CFG_COST_LOW:  cfg.nbr_cost_low  <= cfg_data;
        CFG_COST_HIGH: cfg.nbr_cost_high <= cfg_data;
        CFG_INF_COST:  cfg.infinite_cost <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign item.opcode     = s_tuser;
  assign item.src_node   = s_tdata[2:0];
  assign item.entry_node = s_tdata[5:3];
  assign item.entry_cost = s_tdata[21:6];
  assign item.dest_node  = s_tdata[24:22];
  assign item.last       = s_tlast;

  // every transaction yields one result, so keep a queue slot free
  assign s_tready = seq_idle && (count != 2'd2);
  assign s_accept = s_tvalid && s_tready;

  dvr_seq #(
    .NODES(NODES),
    .COST_BITS(COST_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (s_accept),
    .item    (item),
    .idle    (seq_idle),
    .res_push(res_push),
    .res     (res),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  dvr_store #(
    .NODES(NODES),
    .COST_BITS(COST_BITS)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mem_ctl),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign m_tvalid = (count != 2'd0);
  assign m_pop    = m_tvalid && m_tready;
  assign m_tdata  = {2'b00, queue[rd_ptr].routes_changed, queue[rd_ptr].next_hop,
                     queue[rd_ptr].found, queue[rd_ptr].deliver_local};

  always_ff @(posedge clk) begin
    if (res_push) begin
      queue[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (res_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (m_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (res_push && !m_pop) begin
        count <= count + 2'd1;
      end else if (!res_push && m_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && !m_pop && (count == 2'd2)))
    else $error("result queue overflow");

endmodule

// ----- test/tb_distance_vector_router_core.sv -----
`timescale 1ns / 1ps
module tb_distance_vector_router_core;
  import dvr_pkg::*;

  localparam int NODES = DEFAULT_NODES;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = NODES * (NODES + 1) + 10;
  localparam int MAX_REPORTS = 100;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  distance_vector_router_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // routing state as this node should see it
  logic [2:0]  cf_node = 3'd0;
  logic [7:0]  cf_mask = 8'd0;
  logic [63:0] cf_low = 64'd0;
  logic [63:0] cf_high = 64'd0;
  logic [15:0] cf_inf = RESET_INFINITE;
  logic [15:0] path_cost [NODES][NODES];
  logic [2:0]  hop_of [NODES];
  bit          hop_ok [NODES];

  dvr_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  bit hold_request = 0;
  int idle_levels[4] = '{0, 5, 20, 50};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int r = 0; r < NODES; r++) begin
      hop_of[r] = 3'd0;
      hop_ok[r] = 1'b0;
      for (int c = 0; c < NODES; c++) path_cost[r][c] = RESET_INFINITE;
    end
  end

  function automatic logic [15:0] clamp_cost(input logic [15:0] c);
    return (c < cf_inf) ? c : cf_inf;
  endfunction

  function automatic logic [15:0] link_of(input int n);
    return clamp_cost(n < 4 ? cf_low[16*n +: 16] : cf_high[16*(n-4) +: 16]);
  endfunction

  function automatic bit is_nbr(input int n);
    return (n != int'(cf_node)) && cf_mask[n];
  endfunction

  function automatic void init_tables();
    for (int r = 0; r < NODES; r++)
      for (int c = 0; c < NODES; c++) path_cost[r][c] = cf_inf;
    for (int c = 0; c < NODES; c++) begin
      hop_of[c] = 3'd0;
      hop_ok[c] = 1'b0;
    end
    for (int c = 0; c < NODES; c++) begin
      if (c == int'(cf_node)) begin
        path_cost[cf_node][c] = 16'd0;
      end else if (is_nbr(c)) begin
        path_cost[cf_node][c] = link_of(c);
        hop_of[c] = 3'(c);
        hop_ok[c] = 1'b1;
      end
    end
  endfunction

  // bellman-ford pass over direct neighbors, ascending destination then neighbor
  function automatic bit relax_routes();
    bit changed;
    logic [16:0] sum;
    changed = 1'b0;
    for (int d = 0; d < NODES; d++) begin
      for (int n = 0; n < NODES; n++) begin
        if (!is_nbr(n)) continue;
        sum = {1'b0, link_of(n)} + {1'b0, path_cost[n][d]};
        if (sum > {1'b0, cf_inf}) sum = {1'b0, cf_inf};
        if (sum < {1'b0, path_cost[cf_node][d]}) begin
          path_cost[cf_node][d] = sum[15:0];
          hop_of[d] = 3'(n);
          hop_ok[d] = 1'b1;
          changed = 1'b1;
        end
      end
    end
    return changed;
  endfunction

  function automatic dvr_result_t route_step(input dvr_item_t it);
    dvr_result_t r;
    r = '0;
    case (it.opcode)
      OP_UPDATE: begin
        if (it.src_node != cf_node)
          path_cost[it.src_node][it.entry_node] = clamp_cost(it.entry_cost);
        if (it.last) r.routes_changed = relax_routes();
      end
      OP_LOOKUP: begin
        if (it.dest_node == cf_node) begin
          r.deliver_local = 1'b1;
        end else if (hop_ok[it.dest_node]) begin
          r.found = 1'b1;
          r.next_hop = hop_of[it.dest_node];
        end
      end
      OP_INIT: init_tables();
      default: ;
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    dvr_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[0] !== want.deliver_local || m_tdata[1] !== want.found ||
            m_tdata[4:2] !== want.next_hop || m_tdata[5] !== want.routes_changed) begin
          if (errors < MAX_REPORTS)
            $display("%0t: mismatch, expected local=%0b found=%0b hop=%0d changed=%0b",
                     $time, want.deliver_local, want.found, want.next_hop,
                     want.routes_changed,
                     ", actual local=%0b found=%0b hop=%0d changed=%0b",
                     m_tdata[0], m_tdata[1], m_tdata[4:2], m_tdata[5]);
          errors++;
        end
      end
    end
  end

  // receiver side, including the long hold-off
  initial begin : sink
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_request) begin
          stall_left = HOLD_CYCLES;
          hold_request = 1'b0;
        end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
          stall_left = $urandom_range(8, 1);
        end
      end
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input dvr_item_t it);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, it.dest_node, it.entry_cost, it.entry_node, it.src_node};
    s_tuser <= it.opcode;
    s_tlast <= it.last;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(route_step(it));
    items_sent++;
    @(negedge clk);
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk);
    end
  endtask

  function automatic dvr_item_t rand_item();
    dvr_item_t it;
    it.opcode = 2'($urandom_range(3));
    it.src_node = 3'($urandom_range(7));
    it.entry_node = 3'($urandom_range(7));
    it.entry_cost = 16'($urandom);
    it.dest_node = 3'($urandom_range(7));
    it.last = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic dvr_item_t make_item(input logic [1:0] op, input int src,
                                          input int ent, input int cost,
                                          input int dest, input bit last);
    dvr_item_t it;
    it = rand_item();
    it.opcode = op;
    it.src_node = 3'(src);
    it.entry_node = 3'(ent);
    it.entry_cost = 16'(cost);
    it.dest_node = 3'(dest);
    it.last = last;
    return it;
  endfunction

  // stop offering, let every expected result come back, then sit at a falling edge
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input dvr_cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MY_NODE:   cf_node = val[2:0];
      CFG_NBR_MASK:  cf_mask = val[7:0];
      CFG_COST_LOW:  cf_low = val;
      CFG_COST_HIGH: cf_high = val;
      CFG_INF_COST:  cf_inf = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [63:0] node, input logic [63:0] mask,
                           input logic [63:0] low, input logic [63:0] high,
                           input logic [63:0] inf);
    write_reg(CFG_MY_NODE, node);
    write_reg(CFG_NBR_MASK, mask);
    write_reg(CFG_COST_LOW, low);
    write_reg(CFG_COST_HIGH, high);
    write_reg(CFG_INF_COST, inf);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] lane_cost();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(30, 1));
    endcase
  endfunction

  function automatic logic [15:0] advert_cost();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return cf_inf;
      3: return cf_inf - 16'd1;
      4: return 16'($urandom);
      default: return 16'($urandom_range(40));
    endcase
  endfunction

  function automatic int pick_sender();
    int nbrs[$];
    for (int n = 0; n < NODES; n++)
      if (is_nbr(n)) nbrs.push_back(n);
    if (nbrs.size() == 0 || $urandom_range(9) == 0) return $urandom_range(NODES - 1);
    return nbrs[$urandom_range(nbrs.size() - 1)];
  endfunction

  // one advertised vector, usually from a neighbor, closed by last unless broken off
  task automatic advert_round();
    int src;
    int count;
    bit broken;
    src = pick_sender();
    count = $urandom_range(NODES, 1);
    broken = ($urandom_range(11) == 0);
    for (int i = 0; i < count; i++)
      send_item(make_item(OP_UPDATE, src, $urandom_range(NODES - 1), advert_cost(),
                          $urandom_range(7), !broken && i == count - 1));
  endtask

  task automatic traffic_phase(input int n_items);
    int start;
    int pick;
    start = items_sent;
    send_item(make_item(OP_INIT, 0, 0, 0, 0, 0));
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        advert_round();
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1))
          send_item(make_item(OP_LOOKUP, $urandom_range(7), $urandom_range(7),
                              $urandom, $urandom_range(NODES - 1), $urandom_range(1)));
      end else if (pick < 95) begin
        send_item(rand_item());
      end else begin
        send_item(make_item(OP_INIT, $urandom_range(7), $urandom_range(7), $urandom,
                            $urandom_range(7), $urandom_range(1)));
      end
    end
  endtask

  task automatic random_config(input int ph);
    logic [63:0] junk;
    logic [15:0] inf;
    junk = {$urandom, $urandom};
    case ($urandom_range(4))
      0: inf = 16'd1;
      1: inf = 16'hFFFF;
      2: inf = RESET_INFINITE;
      3: inf = 16'($urandom_range(300, 20));
      default: inf = 16'($urandom_range(16'hFFFF, 1));
    endcase
    case (ph)
      0: configure({junk[63:3], 3'd0}, 64'hFF, 64'd0, 64'd0, 64'd1);
      1: configure(64'd7, {junk[63:8], 8'hFF}, '1, '1, {junk[63:16], 16'hFFFF});
      2: configure(64'd3, 64'd0, {4{lane_cost()}}, {4{lane_cost()}}, 64'd500);
      default:
        configure({junk[63:3], 3'($urandom_range(7))},
                  {junk[63:8], ($urandom_range(4) == 0) ? 8'hFF : 8'($urandom)},
                  {lane_cost(), lane_cost(), lane_cost(), lane_cost()},
                  {lane_cost(), lane_cost(), lane_cost(), lane_cost()},
                  {junk[63:16], inf});
    endcase
  endtask

  task automatic test_reset_defaults();
    send_item(make_item(OP_LOOKUP, 5, 2, 77, 0, 0));
    send_item(make_item(OP_LOOKUP, 1, 6, 0, 3, 1));
    send_item(make_item(OP_UPDATE, 4, 1, 5, 0, 1));
    send_item(make_item(OP_UNUSED, 7, 7, 16'hFFFF, 7, 1));
    send_item(make_item(OP_INIT, 0, 0, 0, 0, 0));
  endtask

  task automatic test_directed_routes();
    settle_block();
    // node 2 with neighbors 1, 3 and 5; own bit in mask must be ignored
    configure(64'd2, 64'b0010_1110, {16'hFFFF, 16'd1, 16'd4, 16'd7},
              {16'd0, 16'd0, 16'd10, 16'd3}, 64'd999);
    send_item(make_item(OP_INIT, 0, 0, 0, 0, 0));
    send_item(make_item(OP_LOOKUP, 0, 0, 0, 2, 0));
    send_item(make_item(OP_LOOKUP, 0, 0, 0, 1, 0));
    send_item(make_item(OP_LOOKUP, 0, 0, 0, 4, 0));
    send_item(make_item(OP_UPDATE, 1, 4, 5, 0, 0));
    // entry from this node itself is dropped
    send_item(make_item(OP_UPDATE, 2, 4, 0, 0, 0));
    send_item(make_item(OP_UPDATE, 5, 4, 0, 0, 1));
    send_item(make_item(OP_LOOKUP, 0, 0, 0, 4, 0));
    // advertised cost above infinity, sums saturate
    send_item(make_item(OP_UPDATE, 5, 0, 16'hFFFF, 0, 1));
    send_item(make_item(OP_UPDATE, 3, 6, 0, 0, 1));
    // equal cost through two neighbors, lower index wins
    send_item(make_item(OP_UPDATE, 5, 6, 3, 0, 0));
    send_item(make_item(OP_UPDATE, 1, 6, 9, 0, 1));
    send_item(make_item(OP_LOOKUP, 0, 0, 0, 6, 0));
    send_item(make_item(OP_UPDATE, 1, 0, 0, 0, 1));
    send_item(make_item(OP_UNUSED, 1, 0, 0, 0, 1));
    send_item(make_item(OP_LOOKUP, 0, 0, 0, 0, 0));
    // non-neighbor row is stored but never used
    send_item(make_item(OP_UPDATE, 7, 3, 0, 0, 1));
  endtask

  task automatic test_random_rounds();
    int ph;
    int target;
    ph = 0;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      settle_block();
      src_gap_pct = idle_levels[$urandom_range(3)];
      sink_stall_pct = idle_levels[$urandom_range(3)];
      random_config(ph);
      traffic_phase($urandom_range(70, 30));
      ph++;
    end
  endtask

  task automatic test_input_backpressure();
    dvr_item_t it;
    settle_block();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    random_config(3);
    send_item(make_item(OP_INIT, 0, 0, 0, 0, 0));
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) begin
      it = rand_item();
      it.opcode = OP_LOOKUP;
      if (i == 12) begin
        it.opcode = OP_UPDATE;
        it.last = 1'b1;
      end
      send_item(it);
    end
  endtask

  task automatic test_quiet_tail();
    settle_block();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    random_config(3);
    traffic_phase(100);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_routes();
    test_random_rounds();
    test_input_backpressure();
    test_quiet_tail();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
